/* rtl/uartrx_pkg.sv */
`timescale 1ns / 1ps

package uartrx_pkg;

   localparam int unsigned DATA_BITS = 8;
   localparam logic [15:0] BIT_TICKS_RESET = 16'd1667;

   typedef struct packed {
      logic rx_line;
      logic pop_request;
      logic flush_request;
   } req_type;

   typedef struct packed {
      logic        byte_received;
      logic [7:0]  received_byte;
      logic [7:0]  head_byte;
      logic        pop_valid;
      logic [5:0]  fifo_count;
      logic [15:0] overflow_count;
      logic [15:0] frame_error_count;
   } rsp_type;

endpackage

/* rtl/uart_rx_with_fifo.sv */
`timescale 1ns / 1ps

// Channel    Ports                             Moves per transfer
// ---------  --------------------------------  -------------------------------------
// input      req_valid, req_stall, req_payload  one line sample, pop and flush request
// result     rsp_valid, rsp_stall, rsp_payload  one status word per sample
// config     csr_write_en, csr_write_data       bit_ticks, ticks per serial bit
//
// One sample is taken per cycle while the result channel is not stalled; each sample
// passes through the input register and then the result register.
// Throughput is set by the single-pass receive/FIFO update between those registers.
// Reset is synchronous and active high; the FIFO storage is not cleared, empty
// entries are never shown. A stalled result holds the input register, which stalls
// the input channel in the same cycle; no transfer is lost or repeated.

module uart_rx_with_fifo #(
   parameter int unsigned FIFO_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  uartrx_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uartrx_pkg::rsp_type rsp_payload,
   input  logic                csr_write_en,
   input  logic [15:0]         csr_write_data
);

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned DW    = (PTR_W + 1 > 6) ? PTR_W + 1 : 6;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [DW-1:0]    DEPTH_DW = DW'(FIFO_DEPTH);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   // control and state
   logic                in_valid_ff;
   uartrx_pkg::req_type in_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   uartrx_pkg::rsp_type rsp_ff, rsp_in;
   logic [15:0]         bit_ticks_ff;
   logic                prev_line_ff, prev_line_in;
   phase_type           phase_ff, phase_in;
   logic [15:0]         tick_ff, tick_in;
   logic [2:0]          bit_pos_ff, bit_pos_in;
   logic [7:0]          shift_ff, shift_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [15:0]         ovf_ff, ovf_in;
   logic [15:0]         ferr_ff, ferr_in;

   // memory
   logic [7:0]          fifo_mem [FIFO_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                byp_ff;
   logic [7:0]          byp_data_ff;

   logic                advance;
   logic                proc;
   logic [15:0]         full_ticks;
   logic [15:0]         half_ticks;
   logic [15:0]         tick_inc;
   logic                store_en;
   logic [PTR_W-1:0]    wr_next;
   logic [PTR_W-1:0]    rd_next;
   logic                empty_before;
   logic [7:0]          head_mem;
   logic [7:0]          head;
   logic [DW-1:0]       wr_dw, rd_dw, occ;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign proc      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign full_ticks = (bit_ticks_ff == 16'd0) ? 16'd1 : bit_ticks_ff;
   assign half_ticks = (full_ticks[15:1] == 15'd0) ? 16'd1 : {1'b0, full_ticks[15:1]};
   assign tick_inc   = tick_ff + 16'd1;
   assign wr_next    = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign head_mem   = byp_ff ? byp_data_ff : rd_data_ff;

   always_comb begin
      prev_line_in = prev_line_ff;
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_pos_in   = bit_pos_ff;
      shift_in     = shift_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      ovf_in       = ovf_ff;
      ferr_in      = ferr_ff;
      store_en     = 1'b0;
      head         = 8'd0;
      empty_before = (rd_ptr_ff == wr_ptr_ff);
      rsp_in       = '0;
      wr_dw        = '0;
      rd_dw        = '0;
      occ          = '0;

      if (proc) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (prev_line_ff && !in_ff.rx_line) begin
                  phase_in = PH_START;
                  tick_in  = 16'd0;
               end
            end
            PH_START: begin
               tick_in = tick_inc;
               if (tick_inc >= half_ticks) begin
                  tick_in = 16'd0;
                  if (in_ff.rx_line) begin
                     phase_in = PH_IDLE;  // glitch
                  end else begin
                     phase_in   = PH_DATA;
                     bit_pos_in = 3'd0;
                     shift_in   = 8'd0;
                  end
               end
            end
            PH_DATA: begin
               tick_in = tick_inc;
               if (tick_inc >= full_ticks) begin
                  tick_in = 16'd0;
                  if (in_ff.rx_line) begin
                     shift_in[bit_pos_ff] = 1'b1;
                  end
                  if (bit_pos_ff == 3'(uartrx_pkg::DATA_BITS - 1)) begin
                     bit_pos_in = 3'd0;
                     phase_in   = PH_STOP;
                  end else begin
                     bit_pos_in = bit_pos_ff + 3'd1;
                  end
               end
            end
            PH_STOP: begin
               tick_in = tick_inc;
               if (tick_inc >= full_ticks) begin
                  tick_in  = 16'd0;
                  phase_in = PH_IDLE;
                  if (!in_ff.rx_line) begin
                     ferr_in = ferr_ff + 16'd1;
                  end else if (wr_next != rd_ptr_ff) begin
                     store_en  = 1'b1;
                     wr_ptr_in = wr_next;
                  end else begin
                     ovf_in = ovf_ff + 16'd1;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
         prev_line_in = in_ff.rx_line;

         // a byte stored into an empty FIFO is the head this tick
         if (!empty_before) begin
            head = head_mem;
         end else if (store_en) begin
            head = shift_ff;
         end

         if (in_ff.pop_request && (rd_ptr_ff != wr_ptr_in)) begin
            rd_ptr_in = rd_next;
         end
         if (in_ff.flush_request) begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
         end

         wr_dw = DW'(wr_ptr_in);
         rd_dw = DW'(rd_ptr_in);
         occ   = (wr_dw >= rd_dw) ? (wr_dw - rd_dw) : (DEPTH_DW + wr_dw - rd_dw);

         rsp_in.byte_received     = store_en;
         rsp_in.received_byte     = store_en ? shift_ff : 8'd0;
         rsp_in.head_byte         = head;
         rsp_in.pop_valid         = in_ff.pop_request && (rd_ptr_ff != wr_ptr_ff || store_en);
         rsp_in.fifo_count        = occ[5:0];
         rsp_in.overflow_count    = ovf_in;
         rsp_in.frame_error_count = ferr_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proc) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bit_ticks_ff <= uartrx_pkg::BIT_TICKS_RESET;
         prev_line_ff <= 1'b1;
         phase_ff     <= PH_IDLE;
         tick_ff      <= 16'd0;
         bit_pos_ff   <= 3'd0;
         shift_ff     <= 8'd0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         ovf_ff       <= 16'd0;
         ferr_ff      <= 16'd0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            bit_ticks_ff <= csr_write_data;
         end
         prev_line_ff <= prev_line_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_pos_ff   <= bit_pos_in;
         shift_ff     <= shift_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         ovf_ff       <= ovf_in;
         ferr_ff      <= ferr_in;
      end
      if (!req_stall) begin
         in_ff <= req_payload;
      end
      if (proc) begin
         rsp_ff <= rsp_in;
      end
   end

   // read the next head every cycle; forward a same-edge write to that entry
   always_ff @(posedge clock) begin
      if (store_en) begin
         fifo_mem[wr_ptr_ff] <= shift_ff;
      end
      rd_data_ff  <= fifo_mem[rd_ptr_in];
      byp_ff      <= store_en && (wr_ptr_ff == rd_ptr_in);
      byp_data_ff <= shift_ff;
   end

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (32'(wr_ptr_ff) < FIFO_DEPTH) && (32'(rd_ptr_ff) < FIFO_DEPTH))
      else $error("FIFO pointer beyond depth");

   a_store_phase: assert property (@(posedge clock) disable iff (reset)
      store_en |-> (phase_ff == PH_STOP) && proc)
      else $error("byte stored outside stop bit");

   a_flush: assert property (@(posedge clock) disable iff (reset)
      (proc && in_ff.flush_request) |=> (wr_ptr_ff == '0) && (rd_ptr_ff == '0))
      else $error("flush left pointers set");

   a_bitpos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DATA) |-> (bit_pos_ff == 3'd0))
      else $error("bit position set outside data phase");

   a_result: assert property (@(posedge clock) disable iff (reset)
      proc |=> rsp_valid_ff)
      else $error("processed sample produced no result");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   typedef enum logic [1:0] {RX_IDLE, RX_START, RX_DATA, RX_STOP} rx_phase_type;

   localparam int RING_SIZE = 64;
   localparam int LIMIT_NS  = 4_000_000;
   localparam int GAP_PCT   = 14;
   localparam int HOLD_OFF_CYCLES = 120;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   uartrx_pkg::req_type req_payload = 3'b100;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   uartrx_pkg::rsp_type rsp_payload;
   logic                csr_write_en = 1'b0;
   logic [15:0]         csr_write_data = '0;

   uart_rx_with_fifo dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // receiver and FIFO shadow, starts in its reset state
   logic [15:0]  bit_period = uartrx_pkg::BIT_TICKS_RESET;
   logic         last_line = 1'b1;
   rx_phase_type rx_phase = RX_IDLE;
   logic [15:0]  tick_count = '0;
   logic [2:0]   bit_index = '0;
   logic [7:0]   shift_data = '0;
   logic [7:0]   ring [RING_SIZE];
   logic [5:0]   wr_ptr = '0;
   logic [5:0]   rd_ptr = '0;
   logic [15:0]  overrun_total = '0;
   logic [15:0]  framing_total = '0;

   uartrx_pkg::req_type tick_queue [$];
   uartrx_pkg::rsp_type status_due [$];
   int      ticks_planned = 0;
   int      ticks_accepted = 0;
   int      statuses_seen = 0;
   int      failures = 0;
   int      pop_pct = 0;
   int      flush_permille = 0;
   bit      gaps_on = 1'b1;
   int      hold_off_seq = 0;
   int      hold_off_done = 0;
   int      hold_left = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic uartrx_pkg::rsp_type sample_tick(uartrx_pkg::req_type t);
      int unsigned         period;
      int unsigned         half;
      logic [5:0]          wr_next;
      uartrx_pkg::rsp_type r;
      period = (bit_period == 16'd0) ? 32'd1 : 32'(bit_period);
      half = (period / 2 == 0) ? 32'd1 : period / 2;
      r = '0;
      case (rx_phase)
         RX_IDLE: begin
            if (last_line && !t.rx_line) begin
               rx_phase = RX_START;
               tick_count = '0;
            end
         end
         RX_START: begin
            tick_count++;
            if (tick_count >= half) begin
               tick_count = '0;
               if (t.rx_line) begin
                  rx_phase = RX_IDLE;
               end else begin
                  rx_phase = RX_DATA;
                  bit_index = '0;
                  shift_data = '0;
               end
            end
         end
         RX_DATA: begin
            tick_count++;
            if (tick_count >= period) begin
               tick_count = '0;
               if (t.rx_line) shift_data[bit_index] = 1'b1;
               if (bit_index == 3'd7) rx_phase = RX_STOP;
               bit_index++;
            end
         end
         default: begin
            tick_count++;
            if (tick_count >= period) begin
               tick_count = '0;
               rx_phase = RX_IDLE;
               if (!t.rx_line) begin
                  framing_total++;
               end else begin
                  wr_next = wr_ptr + 6'd1;
                  if (wr_next != rd_ptr) begin
                     ring[wr_ptr] = shift_data;
                     wr_ptr = wr_next;
                     r.byte_received = 1'b1;
                     r.received_byte = shift_data;
                  end else begin
                     overrun_total++;
                  end
               end
            end
         end
      endcase
      last_line = t.rx_line;
      if (rd_ptr != wr_ptr) r.head_byte = ring[rd_ptr];
      if (t.pop_request && rd_ptr != wr_ptr) begin
         rd_ptr++;
         r.pop_valid = 1'b1;
      end
      if (t.flush_request) begin
         wr_ptr = '0;
         rd_ptr = '0;
      end
      r.fifo_count = wr_ptr - rd_ptr;
      r.overflow_count = overrun_total;
      r.frame_error_count = framing_total;
      return r;
   endfunction

   task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want)
         $display("%0t: %s expected %h got %h", $time, name, want, got);
   endtask

   task automatic check_status(uartrx_pkg::rsp_type want, uartrx_pkg::rsp_type got);
      if (got !== want) begin
         failures++;
         report_field("byte_received", 16'(want.byte_received), 16'(got.byte_received));
         report_field("received_byte", 16'(want.received_byte), 16'(got.received_byte));
         report_field("head_byte", 16'(want.head_byte), 16'(got.head_byte));
         report_field("pop_valid", 16'(want.pop_valid), 16'(got.pop_valid));
         report_field("fifo_count", 16'(want.fifo_count), 16'(got.fifo_count));
         report_field("overflow_count", want.overflow_count, got.overflow_count);
         report_field("frame_error_count", want.frame_error_count, got.frame_error_count);
      end
   endtask

   task automatic push_tick(logic line, bit add_pop = 1'b0, bit add_flush = 1'b0);
      uartrx_pkg::req_type t;
      t.rx_line = line;
      t.pop_request = add_pop || ($urandom_range(99) < pop_pct);
      t.flush_request = add_flush || ($urandom_range(999) < flush_permille);
      tick_queue.push_back(t);
      ticks_planned++;
   endtask

   // end_pop / end_flush land on the tick where the stop bit is sampled
   task automatic push_frame(logic [7:0] data, bit stop_ok = 1'b1, bit short_stop = 1'b0,
                             bit end_pop = 1'b0, bit end_flush = 1'b0);
      int period;
      int half;
      period = int'(bit_period);
      half = (period / 2 == 0) ? 1 : period / 2;
      repeat (period) push_tick(1'b0);
      for (int b = 0; b < 8; b++) repeat (period) push_tick(data[b]);
      if (short_stop) begin
         repeat (half) push_tick(1'b1);
      end else begin
         for (int k = 0; k < period; k++)
            push_tick(stop_ok, end_pop && k == half, end_flush && k == half);
      end
   endtask

   task automatic push_traffic(int frames, int good_pct);
      int period;
      int half;
      period = int'(bit_period);
      half = (period / 2 == 0) ? 1 : period / 2;
      repeat (frames) begin
         if ($urandom_range(99) < good_pct) begin
            push_frame(8'($urandom));
         end else begin
            case ($urandom_range(3))
               0: begin
                  push_frame(8'($urandom), 1'b0);
                  push_tick(1'b1);
               end
               1: begin
                  repeat ($urandom_range(half, 1)) push_tick(1'b0);
                  repeat (period) push_tick(1'b1);
               end
               2: begin
                  // next start edge falls on the stop sample of this frame
                  push_frame(8'($urandom), 1'b1, 1'b1);
                  push_frame(8'($urandom));
               end
               default: begin
                  repeat ($urandom_range(12, 1)) push_tick(1'($urandom_range(1)));
                  repeat (11 * period) push_tick(1'b1);
               end
            endcase
         end
         repeat ($urandom_range(3)) push_tick(1'b1);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (ticks_accepted != ticks_planned || statuses_seen != ticks_planned);
   endtask

   task automatic write_bit_period(logic [15:0] value);
      wait_drained();
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      bit_period = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            status_due.push_back(sample_tick(req_payload));
            ticks_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (tick_queue.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
               req_valid <= 1'b1;
               req_payload <= tick_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               failures++;
               $display("%0t: unexpected transfer, expected nothing got %h", $time, rsp_payload);
            end else begin
               check_status(status_due.pop_front(), rsp_payload);
               statuses_seen++;
            end
         end
         if (hold_off_done != hold_off_seq) begin
            hold_off_done = hold_off_seq;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // pop on empty at the reset bit period
      repeat (3) push_tick(1'b1);
      push_tick(1'b1, 1'b1);

      write_bit_period(16'd2);
      push_frame(8'h00);
      push_frame(8'hFF);
      push_frame(8'hA5, 1'b1, 1'b0, 1'b1);
      push_frame(8'h5A, 1'b1, 1'b0, 1'b0, 1'b1);
      push_frame(8'h3C, 1'b0);
      push_tick(1'b1);
      push_tick(1'b0);
      repeat (3) push_tick(1'b1);
      push_frame(8'h81, 1'b1, 1'b1);
      push_frame(8'h7E);
      repeat (4) push_tick(1'b1);
      push_frame(8'hC3);
      push_frame(8'h18);
      push_tick(1'b1, 1'b1, 1'b1);
      push_tick(1'b1, 1'b1);

      // no pops: fill the FIFO past full, with a long result hold-off on the way;
      // a full FIFO still drops the byte when the pop lands on the stop sample
      repeat (64) push_frame(8'($urandom));
      push_frame(8'($urandom), 1'b1, 1'b0, 1'b1);
      push_frame(8'($urandom));
      repeat (40) @(posedge clock);
      hold_off_seq++;

      write_bit_period(16'd3);
      gaps_on = 1'b0;
      pop_pct = 10;
      flush_permille = 5;
      push_traffic(4, 80);
      wait_drained();
      gaps_on = 1'b1;

      write_bit_period(16'($urandom_range(9, 4)));
      pop_pct = 6;
      push_traffic(1, 80);

      // longest bit period: frame starts but never reaches mid-bit
      write_bit_period(16'hFFFF);
      pop_pct = 20;
      repeat (3) push_tick(1'b1);
      repeat (20) push_tick(1'b0);
      repeat (20) push_tick(1'b1);

      write_bit_period(16'd5);
      repeat (5) push_tick(1'b1);
      push_traffic(1, 80);

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
rtl/uartrx_pkg.sv
rtl/uart_rx_with_fifo.sv
bench/tb_top.sv
